### hw/rtl/psdeh_pkg.sv
// ----------------------------------------------------------------------------
// psdeh_pkg
// Shared types and constants of the pulse shape / energy histogrammer.
// ----------------------------------------------------------------------------
package psdeh_pkg;

  // Scale applied to the pulse shape ratio before the integer quotient.
  localparam int PSD_SCALE = 100;
  // Energy channel width in charge units is four, taken as a right shift.
  localparam int CHAN_SHIFT = 2;
  // Width of the scaled numerator 100 * |long - short|, at most 6553500.
  localparam int PROD_W = 23;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_FIN
  } state_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] energy;
    logic signed [15:0] short_energy;
    logic [6:0]         read_psd_bin;
    logic [11:0]        read_channel_bin;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  psd_bin;
    logic [12:0] channel_bin;
    logic        binned;
    logic [31:0] event_count;
    logic [31:0] bin_count;
  } out_t;

  // Status of the iterative divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/psd_energy_histogrammer_unit.sv
// ----------------------------------------------------------------------------
// psd_energy_histogrammer_unit
// Pulse shape versus energy 2D histogram of detector events, with bin readback.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   psdeh_pkg::in_t   (event or read)
//   out_      output     out_valid / out_stall psdeh_pkg::out_t  (one per request)
//
// An event request passes through ST_PREP, ST_CHECK, ST_DIV, ST_RD, ST_WR
// and ST_FIN before its result is loaded; the divider in ST_DIV produces the
// QW = clog2(PSD_BINS + 1) quotient bits, one bit per cycle. Events that need
// no division (dropped, zero numerator or zero energy, ratio of at least
// 2^QW / 100) skip ST_DIV and finish sooner. A read request passes through
// ST_RD, ST_WR and ST_FIN, its data coming from the registered memory read.
// After reset a clearing pass writes zero to every bin, one per cycle,
// across all PSD_BINS * 2^clog2(CHANNEL_BINS) words (409600 at the defaults);
// in_stall is high meanwhile. The result sits in an output register, so a new
// request is accepted while an earlier result is still held by out_stall.
//
module psd_energy_histogrammer_unit #(
  parameter int PSD_BINS     = 100,
  parameter int CHANNEL_BINS = 4096,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  psdeh_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output psdeh_pkg::out_t  out_data
);

  // Index widths of the two histogram axes and of the flat store address.
  localparam int PA        = $clog2(PSD_BINS);
  localparam int CA        = $clog2(CHANNEL_BINS);
  localparam int AW        = PA + CA;
  localparam int MEM_DEPTH = PSD_BINS * (2 ** CA);
  // Quotient bits: enough to hold PSD_BINS itself, the saturation value.
  localparam int QW        = $clog2(PSD_BINS + 1);
  localparam int DW        = 16 + QW;
  localparam int XW        = psdeh_pkg::PROD_W + 1 + QW;
  localparam int EW        = COUNT_WIDTH + 32;

  psdeh_pkg::state_t state_r, state_nxt;
  psdeh_pkg::in_t    item_r, item_nxt;
  psdeh_pkg::out_t   out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [psdeh_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [16:0]                  ae_r, ae_nxt;
  logic                         neg_r, neg_nxt;
  logic                         skip_r, skip_nxt;
  logic [QW-1:0]                psd_r, psd_nxt;
  logic                         binned_r, binned_nxt;
  logic                         range_r, range_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic [AW-1:0]                clr_addr_r, clr_addr_nxt;
  logic [COUNT_WIDTH-1:0]       total_r, total_nxt;

  // Memory and divider hookup.
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_rdata;
  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [QW-1:0]          div_quot;
  psdeh_pkg::div_stat_t   div_stat;

  // Ratio preparation from the held request.
  logic signed [16:0] e_ext, s_ext, num;
  logic [16:0]        num_abs, e_abs;
  logic               acc;
  logic [15:0]        e_div;
  logic [12:0]        chan_val;
  logic [CA+12:0]     chan_ext;
  logic [PA+6:0]      rp_ext;
  logic [CA+11:0]     rc_ext;
  logic [XW-1:0]      ovf_lhs, ovf_rhs;
  logic               ovf;
  logic               ev_binnable, rd_in_range;
  logic [AW-1:0]      ev_addr, rd_addr;
  logic [QW+6:0]      psd_ext;
  logic [EW-1:0]      total_ext, bin_ext;

  // The ratio is (long - short) / long; the sign test drops an event whose
  // numerator and denominator differ in sign, and a zero numerator or a zero
  // long charge gives a ratio of zero without any division. The magnitude of
  // the long charge needs 17 bits, since the most negative charge has none in
  // 16.
  always_comb begin
    e_ext   = {item_r.energy[15], item_r.energy};
    s_ext   = {item_r.short_energy[15], item_r.short_energy};
    num     = e_ext - s_ext;
    num_abs = num[16] ? 17'(-num) : 17'(num);
    e_abs   = e_ext[16] ? 17'(-e_ext) : 17'(e_ext);
  end

  // A ratio at or beyond 2^QW / 100 is certain to saturate, so the divider
  // only ever sees dividends below divisor * 2^QW.
  assign ovf_lhs      = XW'(prod_r);
  assign ovf_rhs      = XW'(ae_r) << QW;
  assign ovf          = (ovf_lhs >= ovf_rhs);
  assign div_dividend = ovf_lhs[DW-1:0];

  assign acc = (item_r.op == psdeh_pkg::OP_EVENT) && !neg_r;

  // Energy over four for an accepted event with a positive long charge, else channel zero.
  assign e_div    = item_r.energy >> psdeh_pkg::CHAN_SHIFT;
  assign chan_val = (acc && !item_r.energy[15]) ? e_div[12:0] : 13'd0;
  assign chan_ext = (CA + 13)'(chan_val);

  // Only inner bins are counted: both indices from one up to one below their limits.
  assign ev_binnable = acc && (psd_r != '0) && (psd_r < PSD_BINS) &&
                       (chan_val != '0) && (32'(chan_val) < CHANNEL_BINS);
  assign ev_addr     = {psd_r[PA-1:0], chan_ext[CA-1:0]};

  assign rp_ext      = (PA + 7)'(item_r.read_psd_bin);
  assign rc_ext      = (CA + 12)'(item_r.read_channel_bin);
  assign rd_in_range = (32'(item_r.read_psd_bin) < PSD_BINS) &&
                       (32'(item_r.read_channel_bin) < CHANNEL_BINS);
  assign rd_addr     = {rp_ext[PA-1:0], rc_ext[CA-1:0]};

  assign psd_ext = (QW + 7)'(psd_r);

  // Sequencer: next state, datapath register loads and memory controls.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    prod_nxt      = prod_r;
    ae_nxt        = ae_r;
    neg_nxt       = neg_r;
    skip_nxt      = skip_r;
    psd_nxt       = psd_r;
    binned_nxt    = binned_r;
    range_nxt     = range_r;
    addr_nxt      = addr_r;
    clr_addr_nxt  = clr_addr_r;
    total_nxt     = total_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = ev_addr;
    div_start     = 1'b0;
    total_ext     = EW'(total_r);
    bin_ext       = EW'(mem_rdata);

    // A held result leaves as soon as the far side stops stalling.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      psdeh_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = psdeh_pkg::ST_IDLE;
        end
      end
      psdeh_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = (in_data.op == psdeh_pkg::OP_READ) ? psdeh_pkg::ST_RD
                                                          : psdeh_pkg::ST_PREP;
        end
      end
      psdeh_pkg::ST_PREP: begin
        prod_nxt  = psdeh_pkg::PROD_W'(num_abs) *
                    psdeh_pkg::PROD_W'(psdeh_pkg::PSD_SCALE);
        ae_nxt    = e_abs;
        neg_nxt   = (e_ext != '0) && (num != '0) && (num[16] != e_ext[16]);
        skip_nxt  = (e_ext == '0) || (num == '0);
        state_nxt = psdeh_pkg::ST_CHECK;
      end
      psdeh_pkg::ST_CHECK: begin
        if (skip_r || neg_r) begin
          psd_nxt   = '0;
          state_nxt = psdeh_pkg::ST_RD;
        end else if (ovf) begin
          psd_nxt   = QW'(PSD_BINS);
          state_nxt = psdeh_pkg::ST_RD;
        end else begin
          div_start = 1'b1;
          state_nxt = psdeh_pkg::ST_DIV;
        end
      end
      psdeh_pkg::ST_DIV: begin
        if (div_stat.done) begin
          psd_nxt   = (div_quot > PSD_BINS) ? QW'(PSD_BINS) : div_quot;
          state_nxt = psdeh_pkg::ST_RD;
        end
      end
      psdeh_pkg::ST_RD: begin
        if (item_r.op == psdeh_pkg::OP_READ) begin
          range_nxt  = rd_in_range;
          binned_nxt = 1'b0;
          mem_re     = rd_in_range;
          mem_raddr  = rd_addr;
        end else begin
          range_nxt  = 1'b0;
          binned_nxt = ev_binnable;
          mem_re     = ev_binnable;
          mem_raddr  = ev_addr;
          addr_nxt   = ev_addr;
        end
        state_nxt = psdeh_pkg::ST_WR;
      end
      psdeh_pkg::ST_WR: begin
        // Read data arrived; a binned event writes back its bumped count.
        if (binned_r) begin
          mem_we    = 1'b1;
          mem_waddr = addr_r;
          mem_wdata = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);
        end
        state_nxt = psdeh_pkg::ST_FIN;
      end
      psdeh_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          if (acc && !(&total_r)) begin
            total_nxt = total_r + COUNT_WIDTH'(1);
          end
          total_ext           = EW'(total_nxt);
          out_nxt.accepted    = acc;
          out_nxt.psd_bin     = acc ? psd_ext[6:0] : 7'd0;
          out_nxt.channel_bin = chan_val;
          out_nxt.binned      = binned_r;
          out_nxt.event_count = total_ext[31:0];
          out_nxt.bin_count   = range_r ? bin_ext[31:0] : 32'd0;
          out_valid_nxt       = 1'b1;
          state_nxt           = psdeh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psdeh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psdeh_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    out_r    <= out_nxt;
    prod_r   <= prod_nxt;
    ae_r     <= ae_nxt;
    neg_r    <= neg_nxt;
    skip_r   <= skip_nxt;
    psd_r    <= psd_nxt;
    binned_r <= binned_nxt;
    range_r  <= range_nxt;
    addr_r   <= addr_nxt;
  end

  psdeh_div #(
    .QW (QW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (ae_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  psdeh_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW),
    .DW    (COUNT_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_stall  = (state_r != psdeh_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Outside the clearing pass, only a binned event writes the store.
  a_write_only_binned: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != psdeh_pkg::ST_CLEAR) |->
      (state_r == psdeh_pkg::ST_WR && binned_r && item_r.op == psdeh_pkg::OP_EVENT))
    else $error("histogram written outside a binned event");

  // The divider is never restarted while a division is running.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // The accepted-event total never goes down.
  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (total_r >= $past(total_r)))
    else $error("accepted-event total decreased");

  // A finished request waits while the output register still holds a result.
  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psdeh_pkg::ST_FIN && out_valid_r && out_stall) |=>
      (state_r == psdeh_pkg::ST_FIN))
    else $error("result overwrote a stalled output");

endmodule

### hw/rtl/psdeh_div.sv
// ----------------------------------------------------------------------------
// psdeh_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psdeh_div #(
  parameter int QW = 7,
  parameter int DW = 23
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DW-1:0]         dividend,
  input  logic [16:0]           divisor,
  output logic [QW-1:0]         quotient,
  output psdeh_pkg::div_stat_t  stat
);

  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dsr_r, dsr_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          ge;

  // The caller guarantees dividend < divisor * 2^QW, so QW steps suffice.
  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ge       = (rem_r >= dsr_r);
    if (start) begin
      rem_nxt  = dividend;
      dsr_nxt  = DW'(divisor) << (QW - 1);
      q_nxt    = '0;
      cnt_nxt  = CW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_r - dsr_r) : rem_r;
      q_nxt   = {q_r[QW-2:0], ge};
      dsr_nxt = dsr_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### hw/rtl/psdeh_mem.sv
// ----------------------------------------------------------------------------
// psdeh_mem
// Histogram counter store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module psdeh_mem #(
  parameter int DEPTH = 409600,
  parameter int AW    = 19,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the pulse shape / energy histogrammer against a cycle-free predictor.
// Event and read requests go in through a queue-fed driver; each result is
// compared field by field with the oldest predicted result. Random idling
// on both channels exercises the valid/stall handshake.
// ----------------------------------------------------------------------------
module tb;

  localparam int PSD_BINS        = 100;
  localparam int CHANNEL_BINS    = 4096;
  localparam int IDLE_PCT        = 21;
  localparam int RANDOM_REQUESTS = 1950;
  // Quiet cycles run at the end, after the last result has been checked.
  localparam int DRAIN_CYCLES    = 50;
  // The limit leaves room for the clearing pass plus every request meeting
  // long gaps and stalls, several times over.
  localparam int LIMIT_CYCLES    = 2_500_000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  psdeh_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  psdeh_pkg::out_t out_data;

  psd_energy_histogrammer_unit #(
    .PSD_BINS    (PSD_BINS),
    .CHANNEL_BINS(CHANNEL_BINS),
    .COUNT_WIDTH (32)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Requests waiting to be driven, and results predicted for accepted requests.
  psdeh_pkg::in_t  pending_q[$];
  psdeh_pkg::out_t expected_q[$];

  // Predictor state: the 2D counter store (absent key means zero) and the
  // running total of accepted events.
  bit [31:0] bin_counts[int];
  bit [31:0] accepted_total = '0;

  int   requests_sent = 0;
  int   fail_count = 0;
  logic calm;

  // A stretch of requests during which neither side idles, so that the block
  // also runs back to back.
  assign calm = (requests_sent >= 700) && (requests_sent < 1000);

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset is held low from time zero and released once.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor. Works out the result of one accepted request and updates the
  // histogram and the event total. The pulse shape ratio is formed exactly
  // from the signs and magnitudes of the numerator and the long-gate charge.
  // --------------------------------------------------------------------------
  function automatic psdeh_pkg::out_t predict_result(psdeh_pkg::in_t req);
    psdeh_pkg::out_t res;
    int   e;
    int   s;
    int   num;
    int   mag_num;
    int   mag_e;
    int   quot;
    int   key;
    bit   dropped;
    res = '0;
    if (req.op == psdeh_pkg::OP_READ) begin
      key = int'(req.read_psd_bin) * CHANNEL_BINS + int'(req.read_channel_bin);
      if (req.read_psd_bin < PSD_BINS && bin_counts.exists(key)) begin
        res.bin_count = bin_counts[key];
      end
    end else begin
      e = $signed(req.energy);
      s = $signed(req.short_energy);
      num = e - s;
      quot = 0;
      dropped = 1'b0;
      // A zero long-gate charge gives a ratio of zero.
      if (e != 0) begin
        mag_num = (num < 0) ? -num : num;
        mag_e = (e < 0) ? -e : e;
        if (num != 0 && ((num < 0) != (e < 0))) begin
          dropped = 1'b1;
        end else begin
          quot = (psdeh_pkg::PSD_SCALE * mag_num) / mag_e;
        end
      end
      if (!dropped) begin
        res.accepted = 1'b1;
        res.psd_bin = (quot > PSD_BINS) ? 7'(PSD_BINS) : 7'(quot);
        res.channel_bin = (e > 0) ? 13'(e / 4) : '0;
        if (accepted_total != '1) begin
          accepted_total = accepted_total + 1;
        end
        if (res.psd_bin >= 1 && res.psd_bin < PSD_BINS &&
            res.channel_bin >= 1 && res.channel_bin < CHANNEL_BINS) begin
          key = int'(res.psd_bin) * CHANNEL_BINS + int'(res.channel_bin);
          if (!bin_counts.exists(key)) begin
            bin_counts[key] = '0;
          end
          if (bin_counts[key] != '1) begin
            bin_counts[key] = bin_counts[key] + 1;
          end
          res.binned = 1'b1;
        end
      end
    end
    res.event_count = accepted_total;
    return res;
  endfunction

  // Event requests carry random read indexes so that those bits toggle too.
  function automatic psdeh_pkg::in_t make_event(int e, int s);
    psdeh_pkg::in_t r;
    r.op = psdeh_pkg::OP_EVENT;
    r.energy = 16'(e);
    r.short_energy = 16'(s);
    r.read_psd_bin = 7'($urandom);
    r.read_channel_bin = 12'($urandom);
    return r;
  endfunction

  // Read requests carry random charges, which the block must ignore.
  function automatic psdeh_pkg::in_t make_read(int p, int c);
    psdeh_pkg::in_t r;
    r.op = psdeh_pkg::OP_READ;
    r.energy = 16'($urandom);
    r.short_energy = 16'($urandom);
    r.read_psd_bin = 7'(p);
    r.read_channel_bin = 12'(c);
    return r;
  endfunction

  // Appends one request to the tail of the pending queue.
  function automatic void add_request(psdeh_pkg::in_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  task automatic report_field(string name, longint unsigned exp_v,
                              longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver. A request is presented when the queue has one and the random
  // idle draw allows it; once presented, it holds until accepted. The
  // prediction is made at the acceptance edge, so expectations line up in
  // request order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic hold;
    logic launch;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && in_stall;
      launch = 1'b0;
      if (in_valid && !in_stall) begin
        expected_q.insert(expected_q.size(), predict_result(in_data));
        requests_sent <= requests_sent + 1;
      end
      if (!hold && pending_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data <= pending_q.pop_front();
        launch = 1'b1;
      end
      in_valid <= hold || launch;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every accepted result is matched with the oldest expectation;
  // out_stall is raised at random, independently of the result stream.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    psdeh_pkg::out_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          report_field("accepted", exp_r.accepted, out_data.accepted);
          report_field("psd_bin", exp_r.psd_bin, out_data.psd_bin);
          report_field("channel_bin", exp_r.channel_bin, out_data.channel_bin);
          report_field("binned", exp_r.binned, out_data.binned);
          report_field("event_count", exp_r.event_count, out_data.event_count);
          report_field("bin_count", exp_r.bin_count, out_data.bin_count);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int energy_set[8];
    int psd_set[4];
    int pick;
    int i;
    int j;
    int e;
    int s;

    // Directed part: reads of an empty store, out-of-range reads, zero and
    // negative energy, dropped events, ratios above one, channel and pulse
    // shape edges, and read-back of bins that were just counted.
    add_request(make_read(0, 0));
    add_request(make_read(127, 4095));
    add_request(make_event(0, 0));
    add_request(make_event(0, -32768));
    add_request(make_event(-32768, -32768));
    add_request(make_event(-32768, -32700));
    add_request(make_event(-32768, -10000));
    add_request(make_event(-100, -50));
    add_request(make_event(-100, -200));
    add_request(make_event(100, 200));
    add_request(make_event(32767, -32768));
    add_request(make_event(-32768, 32767));
    add_request(make_event(32767, -1));
    add_request(make_event(32767, 32767));
    add_request(make_event(1000, 500));
    add_request(make_event(1000, 500));
    add_request(make_event(16383, 1));
    add_request(make_event(16384, 8192));
    add_request(make_event(4, 3));
    add_request(make_event(3, 1));
    add_request(make_event(1000, 995));
    add_request(make_event(1000, 990));
    add_request(make_read(50, 250));
    add_request(make_read(99, 4095));
    add_request(make_read(1, 250));
    add_request(make_read(100, 250));
    add_request(make_read(25, 1));

    // The random part aims most events at a handful of bins, so counts build
    // up and the read-back requests mostly find nonzero bins.
    foreach (energy_set[k]) energy_set[k] = $urandom_range(16383, 400);
    foreach (psd_set[k]) psd_set[k] = $urandom_range(99, 1);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(99);
      i = $urandom_range(7);
      j = $urandom_range(3);
      if (pick < 45) begin
        // Short charge chosen so that the ratio lands at or just below the
        // target pulse shape bin.
        e = energy_set[i];
        s = e - (psd_set[j] * e + 99) / 100 + $urandom_range(1);
        add_request(make_event(e, s));
      end else if (pick < 60) begin
        add_request(make_event($urandom, $urandom));
      end else if (pick < 68) begin
        // Near the ratio boundaries: zero ratio and above one.
        e = $urandom_range(16383, 1);
        s = $urandom_range(e + 100, 0) - 100;
        add_request(make_event(e, s));
      end else if (pick < 88) begin
        add_request(make_read(psd_set[j] + $urandom_range(1),
                              energy_set[i] >> psdeh_pkg::CHAN_SHIFT));
      end else begin
        add_request(make_read($urandom_range(127), $urandom_range(4095)));
      end
    end

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/psdeh_pkg.sv
hw/rtl/psdeh_div.sv
hw/rtl/psdeh_mem.sv
hw/rtl/psd_energy_histogrammer_unit.sv
bench/tb.sv
